// File: hw/rtl/lru_key_value_cache_core_defines.svh
// assertion macros shared by the lru cache rtl
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lkvc_pkg.sv
// shared constants and types for the lru key/value cache
`default_nettype none

package lkvc_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int RANK_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              look;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] last_rank;
    logic              update;
    logic              put;
    logic              hit;
    logic              evict;
    logic [RANK_W-1:0] hit_rank;
    logic [VAL_W-1:0]  value;
  } cell_cmd_t;

  // what one cell reports back
  typedef struct packed {
    logic              match;
    logic              victim;
    logic              fill;
    logic [RANK_W-1:0] rank;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } cell_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/lru_key_value_cache_core.sv
// Fully associative 16-entry key/value cache with least-recently-used
// replacement, built as a row of slot cells under one controller. A request
// passes three steps: the transfer cycle latches it, the lookup cycle has
// every cell compare its key and mark itself as hit, victim or lowest free
// slot (the free mark ripples from cell to cell), and the update cycle
// rewrites keys, values and ranks and loads the result register. The next
// request is taken on the cycle after the update, so no new request is
// accepted before the last one is through; the update cycle waits while
// the result register still holds an untaken result. The capacity register
// (reset 16, zero acts as one, values above 16 act as 16) is written through
// cfg_wr_en and should change only while no request is in flight.
`default_nettype none
`include "lru_key_value_cache_core_defines.svh"

module lru_key_value_cache_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lkvc_pkg::CAP_W-1:0]     cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_req_type,
  input  wire logic signed [lkvc_pkg::KEY_W-1:0] in_key,
  input  wire logic signed [lkvc_pkg::VAL_W-1:0] in_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_hit,
  output logic signed [lkvc_pkg::VAL_W-1:0]   out_read_value,
  output logic                                out_evicted,
  output logic signed [lkvc_pkg::KEY_W-1:0]   out_evicted_key
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOK   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  localparam int N = lkvc_pkg::NUM_ENTRIES;

  state_t state_r, state_nxt;

  logic [lkvc_pkg::CAP_W-1:0]  cap_r;
  logic [lkvc_pkg::CNT_W-1:0]  occ_r, occ_nxt;
  logic [lkvc_pkg::CNT_W-1:0]  eff_cap;

  logic                        req_put_r;
  logic [lkvc_pkg::KEY_W-1:0]  req_key_r;
  logic [lkvc_pkg::VAL_W-1:0]  req_value_r;

  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [lkvc_pkg::VAL_W-1:0]  out_read_value_r;
  logic                        out_evicted_r;
  logic [lkvc_pkg::KEY_W-1:0]  out_evicted_key_r;

  lkvc_pkg::cell_cmd_t  cmd;
  lkvc_pkg::cell_stat_t stat [N];
  logic [N:0]           claim;

  logic [N-1:0]                match_vec, victim_vec, fill_vec;
  logic                        any_hit, do_evict, can_go, in_xfer;
  logic [lkvc_pkg::RANK_W-1:0] hit_rank;
  logic [lkvc_pkg::VAL_W-1:0]  hit_value;
  logic [lkvc_pkg::KEY_W-1:0]  victim_key;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign can_go   = !out_valid_r || !out_stall;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = lkvc_pkg::CNT_W'(1);
    end else if (32'(cap_r) > 32'(N)) begin
      eff_cap = lkvc_pkg::CNT_W'(N);
    end else begin
      eff_cap = lkvc_pkg::CNT_W'(cap_r);
    end
  end

  // or-reduce the one cell that matched or was picked as victim
  always_comb begin
    hit_rank   = '0;
    hit_value  = '0;
    victim_key = '0;
    for (int i = 0; i < N; i++) begin
      match_vec[i]  = stat[i].match;
      victim_vec[i] = stat[i].victim;
      fill_vec[i]   = stat[i].fill;
      hit_rank      = hit_rank   | (stat[i].match  ? stat[i].rank  : '0);
      hit_value     = hit_value  | (stat[i].match  ? stat[i].value : '0);
      victim_key    = victim_key | (stat[i].victim ? stat[i].key   : '0);
    end
  end

  assign any_hit  = |match_vec;
  assign do_evict = req_put_r && !any_hit && (occ_r >= eff_cap);

  always_comb begin
    cmd.look      = (state_r == ST_LOOK);
    cmd.key       = req_key_r;
    cmd.last_rank = lkvc_pkg::RANK_W'(occ_r - lkvc_pkg::CNT_W'(1));
    cmd.update    = (state_r == ST_UPDATE) && can_go;
    cmd.put       = req_put_r;
    cmd.hit       = any_hit;
    cmd.evict     = do_evict;
    cmd.hit_rank  = hit_rank;
    cmd.value     = req_value_r;
  end

  assign claim[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lkvc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .claim_in  (claim[g]),
      .claim_out (claim[g+1]),
      .stat      (stat[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (can_go) begin
          state_nxt = ST_IDLE;
          if (req_put_r && !any_hit && !do_evict) begin
            occ_nxt = occ_r + lkvc_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_put_r   <= (in_req_type == lkvc_pkg::REQ_PUT);
      req_key_r   <= in_key;
      req_value_r <= in_value;
    end
    if (cmd.update) begin
      out_hit_r         <= any_hit;
      out_read_value_r  <= (any_hit && !req_put_r) ? hit_value : '1;
      out_evicted_r     <= do_evict;
      out_evicted_key_r <= do_evict ? victim_key : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      cap_r       <= lkvc_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.update) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  `LKVC_ASSERT_NOW(a_match_onehot0, state_r == ST_UPDATE, $onehot0(match_vec), "two cells hit")
  `LKVC_ASSERT_NOW(a_victim_onehot, cmd.update && do_evict, $onehot(victim_vec), "no single victim")
  `LKVC_ASSERT_NOW(a_fill_onehot, cmd.update && req_put_r && !any_hit && !do_evict, $onehot(fill_vec), "no single free slot")
  `LKVC_ASSERT_NOW(a_occ_bound, 1'b1, 32'(occ_r) <= 32'(N), "occupancy above entry count")
  `LKVC_ASSERT_NEXT(a_update_done, cmd.update, out_valid && (state_r == ST_IDLE), "update did not post a result")

endmodule

`default_nettype wire

// File: hw/rtl/lkvc_cell.sv
// one cache slot: key, value, valid bit and recency rank
`default_nettype none

module lkvc_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lkvc_pkg::cell_cmd_t cmd,
  input  wire logic               claim_in,
  output logic                    claim_out,
  output lkvc_pkg::cell_stat_t    stat
);

  logic [lkvc_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [lkvc_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic                        valid_r, valid_nxt;
  logic [lkvc_pkg::RANK_W-1:0] rank_r, rank_nxt;
  logic                        match_r, match_nxt;
  logic                        victim_r, victim_nxt;
  logic                        fill_r, fill_nxt;
  logic                        target;

  // free-slot claim ripples from the low cell upward
  assign claim_out = claim_in | ~valid_r;

  assign target = cmd.evict ? victim_r : fill_r;

  always_comb begin
    key_nxt    = key_r;
    value_nxt  = value_r;
    valid_nxt  = valid_r;
    rank_nxt   = rank_r;
    match_nxt  = match_r;
    victim_nxt = victim_r;
    fill_nxt   = fill_r;
    if (cmd.look) begin
      match_nxt  = valid_r && (key_r == cmd.key);
      victim_nxt = valid_r && (rank_r == cmd.last_rank);
      fill_nxt   = ~valid_r & ~claim_in;
    end
    if (cmd.update) begin
      if (cmd.hit) begin
        if (match_r) begin
          rank_nxt = '0;
          if (cmd.put) begin
            value_nxt = cmd.value;
          end
        end else if (valid_r && (rank_r < cmd.hit_rank)) begin
          rank_nxt = rank_r + lkvc_pkg::RANK_W'(1);
        end
      end else if (cmd.put) begin
        if (target) begin
          key_nxt   = cmd.key;
          value_nxt = cmd.value;
          valid_nxt = 1'b1;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + lkvc_pkg::RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      rank_r   <= '0;
      match_r  <= 1'b0;
      victim_r <= 1'b0;
      fill_r   <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      rank_r   <= rank_nxt;
      match_r  <= match_nxt;
      victim_r <= victim_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign stat.match  = match_r;
  assign stat.victim = victim_r;
  assign stat.fill   = fill_r;
  assign stat.rank   = rank_r;
  assign stat.key    = key_r;
  assign stat.value  = value_r;

endmodule

`default_nettype wire
